// ----- rtl/frpm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the frame RMS and peak level meter.
// No dependencies; every module of the meter imports this package.
package frpm_pkg;

   // Default parameter values.
   localparam int DEF_MAX_FRAME   = 1024;
   localparam int DEF_SAMPLE_BITS = 24;

   // Configuration register widths, indexes and reset values.
   localparam int FS_W    = 24;
   localparam int LVL_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_DBFS = 1'd1;
   localparam logic [FS_W-1:0]         FULL_SCALE_RST = 24'd8388608;
   localparam logic signed [LVL_W-1:0] FLOOR_DBFS_RST = -16'sd30720;
   localparam logic signed [LVL_W-1:0] LVL_MAX        = 16'sd32767;

   // Logarithm: fraction bits and 10*log10(2) in Q.16.
   localparam int LOG_FRAC = 16;
   localparam int STEP_W   = 4;
   localparam logic signed [19:0] DB_K = 20'sd197283;

   // Log unit sequencer.
   typedef enum logic [1:0] {
      L_IDLE,
      L_NORM,
      L_SQR
   } log_state_type;

   // Back-end sequencer.
   typedef enum logic [2:0] {
      B_IDLE,
      B_START,
      B_LOG,
      B_MUL_RMS,
      B_RND_RMS,
      B_MUL_PK,
      B_RND_PK,
      B_OUT
   } back_state_type;

endpackage

// ----- rtl/frpm_front.sv -----
`timescale 1ns / 1ps
// Front end: takes samples, accumulates square sum, peak and count per frame.
// Depends on frpm_pkg; pushes one frame summary into the queue at frame end.
module frpm_front #(
   parameter int MAX_FRAME   = frpm_pkg::DEF_MAX_FRAME,
   parameter int SAMPLE_BITS = frpm_pkg::DEF_SAMPLE_BITS,
   parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8,
   parameter int CNT_W       = $clog2(MAX_FRAME + 1),
   parameter int SUM_W       = 2 * SAMPLE_BITS + CNT_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   input  logic                   push_ready,
   output logic                   push_valid,
   output logic [SUM_W-1:0]       push_sum,
   output logic [SAMPLE_BITS-1:0] push_peak,
   output logic [CNT_W-1:0]       push_count
);
   import frpm_pkg::*;

   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]   peak_ff, peak_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [SAMPLE_BITS-1:0]   raw;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] sq;
   logic                     take;
   logic                     accept;
   logic [SUM_W-1:0]         sum_new;
   logic [SAMPLE_BITS-1:0]   peak_new;
   logic [CNT_W-1:0]         count_new;

   // Input is held off only while the queue has no room for a summary.
   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;

   // Magnitude and square of the incoming sample.
   assign raw  = req_tdata[SAMPLE_BITS-1:0];
   assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign sq   = mag * mag;
   assign take = req_tuser && (count_ff < CNT_W'(MAX_FRAME));

   // Frame totals including the current sample.
   always_comb begin
      sum_new   = sum_ff;
      peak_new  = peak_ff;
      count_new = count_ff;
      if (take) begin
         sum_new   = sum_ff + SUM_W'(sq);
         peak_new  = (mag > peak_ff) ? mag : peak_ff;
         count_new = count_ff + 1'b1;
      end
   end

   // Hand the summary over at frame end and clear for the next frame.
   always_comb begin
      sum_in   = sum_ff;
      peak_in  = peak_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_tlast) begin
            sum_in   = '0;
            peak_in  = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_new;
            peak_in  = peak_new;
            count_in = count_new;
         end
      end
   end

   assign push_valid = accept && req_tlast;
   assign push_sum   = sum_new;
   assign push_peak  = peak_new;
   assign push_count = count_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         peak_ff  <= peak_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/frpm_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry queue of frame summaries between front and back end.
// Imports frpm_pkg but uses nothing from it; width comes from the parent.
module frpm_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   import frpm_pkg::*;

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = data_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed.
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/frpm_log2.sv -----
`timescale 1ns / 1ps
// Iterative log2 unit: result in Q.16, integer part from the top set bit.
// Depends on frpm_pkg; normalizes up to 8 bits a cycle, then squares 16 times.
module frpm_log2 #(
   parameter int LOG_W = 58,
   parameter int EXP_W = $clog2(LOG_W),
   parameter int LV_W  = EXP_W + frpm_pkg::LOG_FRAC
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [LOG_W-1:0] operand,
   output logic             done,
   output logic [LV_W-1:0]  result
);
   import frpm_pkg::*;

   log_state_type        state_ff, state_in;
   logic [LOG_W-1:0]     work_ff, work_in;
   logic [EXP_W-1:0]     shift_ff, shift_in;
   logic [30:0]          mant_ff, mant_in;
   logic [LOG_FRAC-1:0]  frac_ff, frac_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 done_ff, done_in;
   logic [61:0]          square;
   logic [31:0]          mant_sq;

   assign square  = mant_ff * mant_ff;
   assign mant_sq = square[61:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      shift_ff <= shift_in;
      mant_ff  <= mant_in;
      frac_ff  <= frac_in;
      step_ff  <= step_in;
   end

   // Sequencer: normalize, then one squaring step per fraction bit.
   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      shift_in = shift_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               // A zero operand is taken as one.
               work_in  = (operand == '0) ? LOG_W'(1) : operand;
               shift_in = '0;
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            if (work_ff[LOG_W-1]) begin
               mant_in  = work_ff[LOG_W-1 -: 31];
               frac_in  = '0;
               step_in  = '0;
               state_in = L_SQR;
            end else if (work_ff[LOG_W-1 -: 8] == 8'd0) begin
               work_in  = work_ff << 8;
               shift_in = shift_ff + EXP_W'(8);
            end else begin
               work_in  = work_ff << 1;
               shift_in = shift_ff + 1'b1;
            end
         end
         L_SQR: begin
            mant_in = mant_sq[31] ? mant_sq[31:1] : mant_sq[30:0];
            frac_in = {frac_ff[LOG_FRAC-2:0], mant_sq[31]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(LOG_FRAC - 1)) begin
               state_in = L_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   assign done   = done_ff;
   assign result = {EXP_W'(LOG_W - 1) - shift_ff, frac_ff};

endmodule

// ----- rtl/frpm_back.sv -----
`timescale 1ns / 1ps
// Back end: turns one frame summary into RMS and peak levels in Q7.8 dB.
// Depends on frpm_pkg and frpm_log2; holds the result in an output register.
module frpm_back #(
   parameter int SAMPLE_BITS = frpm_pkg::DEF_SAMPLE_BITS,
   parameter int CNT_W       = 11,
   parameter int SUM_W       = 58,
   parameter int LOG_W       = (SUM_W > 31) ? SUM_W : 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [frpm_pkg::FS_W-1:0]          full_scale,
   input  logic signed [frpm_pkg::LVL_W-1:0]  floor_dbfs,
   input  logic                               sum_valid,
   output logic                               sum_pop,
   input  logic [SUM_W-1:0]                   sum_in_data,
   input  logic [SAMPLE_BITS-1:0]             peak_in_data,
   input  logic [CNT_W-1:0]                   count_in_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [2*frpm_pkg::LVL_W-1:0]       rsp_tdata
);
   import frpm_pkg::*;

   localparam int EXP_W = $clog2(LOG_W);
   localparam int LV_W  = EXP_W + LOG_FRAC;
   localparam int T_W   = LV_W + 3;
   localparam int P_W   = T_W + 20;
   localparam int R_W   = P_W - 23;

   back_state_type            state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]    peak_ff, peak_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [LV_W-1:0]           lg_ff [4];
   logic signed [P_W-1:0]     prod_ff, prod_in;
   logic signed [LVL_W-1:0]   rms_ff, rms_in;
   logic signed [LVL_W-1:0]   pk_ff, pk_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [LVL_W-1:0]   out_rms_ff, out_rms_in;
   logic signed [LVL_W-1:0]   out_pk_ff, out_pk_in;
   logic                      log_start;
   logic [LOG_W-1:0]          log_operand;
   logic                      log_done;
   logic [LV_W-1:0]           log_result;
   logic signed [T_W-1:0]     t_rms;
   logic signed [T_W-1:0]     t_pk;
   logic signed [P_W-1:0]     t_ext;
   logic [P_W-1:0]            prod_mag;
   logic [P_W-1:0]            rnd_sum;
   logic signed [R_W-1:0]     rnd;
   logic signed [R_W-1:0]     floor_ext;
   logic signed [R_W-1:0]     clamped;
   logic signed [LVL_W-1:0]   level;
   logic                      rms_silent;
   logic                      pk_silent;

   frpm_log2 #(
      .LOG_W (LOG_W)
   ) u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .operand (log_operand),
      .done    (log_done),
      .result  (log_result)
   );

   // Operand order: full scale, square sum, count, peak.
   always_comb begin
      case (op_ff)
         2'd0:    log_operand = LOG_W'(full_scale);
         2'd1:    log_operand = LOG_W'(sum_ff);
         2'd2:    log_operand = LOG_W'(count_ff);
         default: log_operand = LOG_W'(peak_ff);
      endcase
   end

   // Level exponents in Q.16.
   assign t_rms = $signed(T_W'(lg_ff[1])) - $signed(T_W'(lg_ff[2]))
                - $signed(T_W'({lg_ff[0], 1'b0}));
   assign t_pk  = $signed(T_W'({lg_ff[3], 1'b0})) - $signed(T_W'({lg_ff[0], 1'b0}));
   assign t_ext = (state_ff == B_MUL_PK) ? P_W'(t_pk) : P_W'(t_rms);

   // Round half away from zero, then floor and saturate.
   assign prod_mag  = prod_ff[P_W-1] ? P_W'(-prod_ff) : P_W'(prod_ff);
   assign rnd_sum   = prod_mag + P_W'(24'h800000);
   assign floor_ext = R_W'(floor_dbfs);
   always_comb begin
      rnd     = $signed(R_W'(rnd_sum[P_W-1:24]));
      if (prod_ff[P_W-1]) begin
         rnd = -rnd;
      end
      clamped = (rnd < floor_ext) ? floor_ext : rnd;
      level   = (clamped > R_W'(LVL_MAX)) ? LVL_MAX : LVL_W'(clamped);
   end

   assign rms_silent = (count_ff == '0) || (sum_ff == '0);
   assign pk_silent  = (count_ff == '0) || (peak_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      sum_ff     <= sum_in;
      peak_ff    <= peak_in;
      count_ff   <= count_in;
      prod_ff    <= prod_in;
      rms_ff     <= rms_in;
      pk_ff      <= pk_in;
      out_rms_ff <= out_rms_in;
      out_pk_ff  <= out_pk_in;
      if (log_done) begin
         lg_ff[op_ff] <= log_result;
      end
   end

   // Sequencer over the four logarithms and the two level conversions.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      rms_in       = rms_ff;
      pk_in        = pk_ff;
      out_rms_in   = out_rms_ff;
      out_pk_in    = out_pk_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      sum_pop      = 1'b0;
      log_start    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (sum_valid) begin
               sum_in   = sum_in_data;
               peak_in  = peak_in_data;
               count_in = count_in_data;
               sum_pop  = 1'b1;
               op_in    = 2'd0;
               state_in = B_START;
            end
         end
         B_START: begin
            log_start = 1'b1;
            state_in  = B_LOG;
         end
         B_LOG: begin
            if (log_done) begin
               if (op_ff == 2'd3) begin
                  state_in = B_MUL_RMS;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = B_START;
               end
            end
         end
         B_MUL_RMS: begin
            prod_in  = t_ext * P_W'(DB_K);
            state_in = B_RND_RMS;
         end
         B_RND_RMS: begin
            rms_in   = rms_silent ? floor_dbfs : level;
            state_in = B_MUL_PK;
         end
         B_MUL_PK: begin
            prod_in  = t_ext * P_W'(DB_K);
            state_in = B_RND_PK;
         end
         B_RND_PK: begin
            pk_in    = pk_silent ? floor_dbfs : level;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_rms_in   = rms_ff;
               out_pk_in    = pk_ff;
               out_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pk_ff, out_rms_ff};

`ifndef SYNTHESIS
   // A reported level is never below the configured floor.
   a_rms_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_rms_ff >= floor_dbfs))
      else $error("rms level below floor");
   a_pk_floor: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_pk_ff >= floor_dbfs))
      else $error("peak level below floor");
   // The log unit only finishes while the sequencer waits for it.
   a_log_done: assert property (@(posedge clock) disable iff (reset)
      log_done |-> (state_ff == B_LOG))
      else $error("log result outside of wait state");
   // A summary is taken only when the sequencer is free.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      sum_pop |=> (state_ff == B_START))
      else $error("summary popped without starting");
`endif

endmodule

// ----- rtl/frame_rms_peak_dbfs_meter_top.sv -----
`timescale 1ns / 1ps
// The back end computes all four logarithms of a frame, one after another, on its shared log2 unit.
// Throughput: one sample request per cycle; the two-entry summary queue lets the back end
// overlap the next frame, and frames shorter than the back end's time stall the input.
// Reset: synchronous, active high; clears accumulators, queue, sequencers and output valid,
// and loads full_scale = 8388608 and floor_dbfs = -120 dB.
module frame_rms_peak_dbfs_meter_top #(
   parameter int MAX_FRAME   = frpm_pkg::DEF_MAX_FRAME,
   parameter int SAMPLE_BITS = frpm_pkg::DEF_SAMPLE_BITS,
   parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [DATA_W-1:0]                 req_tdata,  // sample
   input  logic                              req_tuser,  // carries_sample
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*frpm_pkg::LVL_W-1:0]      rsp_tdata,  // rms_level, peak_level
   input  logic                              csr_we,
   input  logic [frpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [frpm_pkg::FS_W-1:0]         csr_wdata
);
   import frpm_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int SUM_W = 2 * SAMPLE_BITS + CNT_W;
   localparam int Q_W   = SUM_W + SAMPLE_BITS + CNT_W;

   logic [FS_W-1:0]         full_scale_ff, full_scale_in;
   logic signed [LVL_W-1:0] floor_ff, floor_in;
   logic                    push_valid;
   logic                    push_ready;
   logic [SUM_W-1:0]        push_sum;
   logic [SAMPLE_BITS-1:0]  push_peak;
   logic [CNT_W-1:0]        push_count;
   logic                    pop_valid;
   logic                    pop;
   logic [Q_W-1:0]          pop_data;

   // Configuration registers.
   always_comb begin
      full_scale_in = full_scale_ff;
      floor_in      = floor_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FULL_SCALE: full_scale_in = csr_wdata;
            CSR_FLOOR_DBFS: floor_in      = $signed(csr_wdata[LVL_W-1:0]);
            default:        full_scale_in = full_scale_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RST;
         floor_ff      <= FLOOR_DBFS_RST;
      end else begin
         full_scale_ff <= full_scale_in;
         floor_ff      <= floor_in;
      end
   end

   frpm_front #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_W      (DATA_W),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_sum   (push_sum),
      .push_peak  (push_peak),
      .push_count (push_count)
   );

   frpm_fifo #(
      .WIDTH (Q_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_count, push_peak, push_sum}),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   frpm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .full_scale    (full_scale_ff),
      .floor_dbfs    (floor_ff),
      .sum_valid     (pop_valid),
      .sum_pop       (pop),
      .sum_in_data   (pop_data[SUM_W-1:0]),
      .peak_in_data  (pop_data[SUM_W +: SAMPLE_BITS]),
      .count_in_data (pop_data[Q_W-1 -: CNT_W]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
